### rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock, quiet during reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

### rtl/core/tnlo_pkg.sv
// Package: types and constants of the two-neuron LIF oscillator
package tnlo_pkg;
    localparam int FRAC = 12;
    localparam int ONE = 1 << FRAC;
    localparam logic [2:0] REG_THR = 3'd0;
    localparam logic [2:0] REG_GAIN = 3'd1;
    localparam logic [2:0] REG_W12 = 3'd2;
    localparam logic [2:0] REG_W21 = 3'd3;
    localparam logic [2:0] REG_WS1 = 3'd4;
    localparam logic [2:0] REG_WS2 = 3'd5;
    localparam logic [2:0] REG_BIAS = 3'd6;
    localparam logic [2:0] REG_VRST = 3'd7;
    localparam logic signed [15:0] POT_ONE_RESET = 16'sd3768;
    localparam logic signed [17:0] CLAMP_LO = -18'sd2048;
    localparam logic [17:0] HI_MARGIN = 18'd819;
    localparam logic [11:0] GAIN_MAX = 12'd2048;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LEAK, ST_FIX, ST_DIV, ST_SMOOTH, ST_NEXT, ST_OUT
    } state_t;
endpackage

### rtl/core/two_neuron_lif_oscillator_unit.sv
// Top level: two coupled LIF neurons advanced by one shared sequencer
// A load action's result is registered in the cycle after it is accepted; an advance runs the leak,
// fix, divide, smooth and next steps for each neuron in turn. Throughput: one item at a time; next
// item accepted the cycle after the result transfers. The rate divide is a restoring divider, one quotient bit a cycle.
// One shared 18x13 multiplier serves the leak of both neurons.
// Reset: async active-low, registers to model reset values, no clearing pass.
`include "assert_macros.svh"
module two_neuron_lif_oscillator_unit
    import tnlo_pkg::*;
#(
    parameter int REFRACTORY_TICKS = 80
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic signed [15:0] load_potential_one,
    input  logic signed [15:0] load_potential_two,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [12:0]        motor_one_out,
    output logic [12:0]        motor_two_out,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    logic [14:0] thr_reg;
    logic [11:0] gain_reg;
    logic signed [15:0] w12_reg, w21_reg, ws1_reg, ws2_reg, bias_reg, vrst_reg;
    logic signed [15:0] pot_reg [2];
    logic [12:0] sm_reg [2];
    logic [7:0] ref_reg [2];
    logic sp1_reg, sp2_reg, sel_reg;
    logic signed [34:0] prod_reg;
    logic [25:0] rem_reg;
    logic [12:0] quo_reg;
    logic [3:0] cnt_reg;
    logic out_valid_reg;
    state_t state_reg, state_next;

    logic [15:0] thr_e;
    logic [11:0] g_eff;
    logic signed [17:0] hi_lim, cur_c;
    logic signed [34:0] prod_r;
    logic signed [17:0] v_leak, v_fix;
    logic [7:0] ref_fix;
    logic [26:0] trial;
    logic [16:0] sm9;
    logic [32:0] sm_div;
    logic [12:0] sm_new;

    assign thr_e = (thr_reg == 15'd0) ? 16'd1 : {1'b0, thr_reg};
    assign g_eff = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
    assign hi_lim = ($signed({2'b00, thr_e}) + $signed(HI_MARGIN) > 18'sd32767)
        ? 18'sd32767 : $signed({2'b00, thr_e}) + $signed(HI_MARGIN);
    assign cur_c = sel_reg
        ? 18'(bias_reg) + (sp2_reg ? 18'(ws2_reg) : 18'sd0) + (sp1_reg ? 18'(w12_reg) : 18'sd0)
        : 18'(bias_reg) + (sp1_reg ? 18'(ws1_reg) : 18'sd0) + (sp2_reg ? 18'(w21_reg) : 18'sd0);
    assign prod_r = prod_reg + 35'sd2048;
    assign v_leak = 18'(pot_reg[sel_reg]) + 18'(prod_r >>> FRAC);
    // fire check and clamp follow the leak or refractory hold
    always_comb
    begin
        v_fix = (ref_reg[sel_reg] == 8'd0) ? v_leak : 18'(vrst_reg);
        ref_fix = (ref_reg[sel_reg] == 8'd0) ? 8'd0 : ref_reg[sel_reg] - 8'd1;
        if (v_fix >= $signed({2'b00, thr_e}))
        begin
            v_fix = 18'(vrst_reg);
            ref_fix = 8'(REFRACTORY_TICKS);
        end
        if (v_fix < CLAMP_LO) v_fix = CLAMP_LO;
        if (v_fix > hi_lim) v_fix = hi_lim;
    end
    // remainder stays below twice the threshold, so 13 steps give v*ONE/thr
    assign trial = {1'b0, rem_reg} - 27'(thr_e);
    assign sm9 = 17'(sm_reg[sel_reg]) * 17'd9 + 17'(quo_reg) + 17'd5;
    // divide by 10 as a reciprocal multiply, exact for sums below 2^16
    assign sm_div = {16'd0, sm9} * 33'd52429;
    assign sm_new = sm_div[31:19];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = action ? ST_OUT : ST_LEAK;
            ST_LEAK:   state_next = ST_FIX;
            ST_FIX:    state_next = ST_DIV;
            ST_DIV:    if (cnt_reg == 4'd12) state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_NEXT;
            ST_NEXT:   state_next = sel_reg ? ST_OUT : ST_LEAK;
            ST_OUT:    if (!out_stall) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign motor_one_out = sm_reg[0];
    assign motor_two_out = sm_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            thr_reg <= 15'd4096;
            gain_reg <= 12'd41;
            w12_reg <= '0; w21_reg <= '0; ws1_reg <= '0; ws2_reg <= '0;
            bias_reg <= '0; vrst_reg <= '0;
            pot_reg[0] <= POT_ONE_RESET; pot_reg[1] <= '0;
            sm_reg[0] <= '0; sm_reg[1] <= '0;
            ref_reg[0] <= '0; ref_reg[1] <= '0;
            sel_reg <= 1'b0; sp1_reg <= 1'b0; sp2_reg <= 1'b0;
            prod_reg <= '0; rem_reg <= '0; quo_reg <= '0;
            cnt_reg <= '0; out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_THR:  thr_reg <= cfg_data[14:0];
                    REG_GAIN: gain_reg <= cfg_data[11:0];
                    REG_W12:  w12_reg <= cfg_data;
                    REG_W21:  w21_reg <= cfg_data;
                    REG_WS1:  ws1_reg <= cfg_data;
                    REG_WS2:  ws2_reg <= cfg_data;
                    REG_BIAS: bias_reg <= cfg_data;
                    REG_VRST: vrst_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sel_reg <= 1'b0;
                        if (action)
                        begin
                            pot_reg[0] <= load_potential_one;
                            pot_reg[1] <= load_potential_two;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            sp1_reg <= $signed(pot_reg[0]) >= $signed({1'b0, thr_e});
                            sp2_reg <= $signed(pot_reg[1]) >= $signed({1'b0, thr_e});
                        end
                    end
                end
                ST_LEAK:
                begin
                    prod_reg <= 35'(cur_c - 18'(pot_reg[sel_reg])) * $signed({1'b0, g_eff});
                end
                ST_FIX:
                begin
                    pot_reg[sel_reg] <= 16'(v_fix);
                    ref_reg[sel_reg] <= ref_fix;
                    cnt_reg <= '0;
                    quo_reg <= '0;
                    rem_reg <= (v_fix <= 0) ? 26'd0
                        : (v_fix >= $signed({2'b00, thr_e})) ? 26'(thr_e)
                        : 26'(v_fix[15:0]);
                end
                ST_DIV:
                begin
                    // restoring step: quotient bit 12-cnt
                    if (!trial[26])
                    begin
                        rem_reg <= trial[25:0] << 1;
                        quo_reg <= {quo_reg[11:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_reg << 1;
                        quo_reg <= {quo_reg[11:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 4'd1;
                end
                ST_SMOOTH: sm_reg[sel_reg] <= sm_new;
                ST_NEXT:
                begin
                    if (sel_reg) out_valid_reg <= 1'b1;
                    sel_reg <= 1'b1;
                end
                ST_OUT: if (!out_stall) out_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_valid_in_out, clk, rst_n, out_valid, state_reg == ST_OUT)
    `ASSERT_IMPL(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `ASSERT_NEXT(a_div_end, clk, rst_n, state_reg == ST_DIV && cnt_reg == 4'd12, state_reg == ST_SMOOTH)
    `ASSERT_IMPL(a_smooth_range, clk, rst_n, 1'b1, sm_reg[0] <= 13'd4096 && sm_reg[1] <= 13'd4096)
endmodule
